FILE: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg - shared types and codes for the positional list engine
// Request and response transaction layouts, operation and status codes and
// the per-transaction cell control word.
// ----------------------------------------------------------------------------
package ple_pkg;

  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_POS  = 3'd0,
    FN_REM_POS  = 3'd1,
    FN_INS_HEAD = 3'd2,
    FN_INS_TAIL = 3'd3,
    FN_REM_HEAD = 3'd4,
    FN_REM_TAIL = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   removed_value;
    logic [COUNT_W-1:0]  count;
  } rsp_t;

  // shift command broadcast along the row of cells
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

FILE: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine - ordered list held in a row of shifting cells
// Insert and remove at a position, the head or the tail.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: req is taken at a clock edge with start high and busy
//   low. busy is never raised, so a transaction may be issued every cycle.
//   Response channel: rsp is valid for the single cycle in which done is
//   high, in the cycle after the request edge (throughput 1/cycle).
//   The whole row of cells shifts in the accepting cycle, so the next
//   request already sees the updated list.
//   The response cannot be held off; it must be captured when done is high.
//   Config: capacity is written with cfg_we/cfg_data while the engine is
//   idle; values above DEPTH act as DEPTH.
//   Reset (rst, synchronous) empties the list and sets capacity to 64.
//   A rejected transaction (full, empty, bad position) leaves the list
//   unchanged; function codes six and seven return ok with no change.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int unsigned DEPTH       = 64,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  ple_pkg::req_t                 req,
  output logic                          done,
  output ple_pkg::rsp_t                 rsp,
  input  logic                          cfg_we,
  input  logic [ple_pkg::COUNT_W-1:0]   cfg_data
);
  import ple_pkg::*;

  localparam int unsigned CNT_MAX = (1 << COUNT_W) - 1;
  localparam int unsigned CAP_LIM = (DEPTH > CNT_MAX) ? CNT_MAX : DEPTH;

  logic [COUNT_W-1:0] capacity;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic [COUNT_W-1:0] cap_eff;

  logic               accept;
  logic               is_ins;
  logic               is_rem;
  logic               full;
  logic               empty;
  logic [1:0]         status_next;
  logic [POS_W-1:0]   op_pos;
  cell_ctl_t          ctl;

  logic [VALUE_WIDTH-1:0] new_data;
  logic [VALUE_WIDTH-1:0] cell_data [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_sel  [DEPTH];
  logic [VALUE_WIDTH-1:0] picked;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign cap_eff = (capacity > COUNT_W'(CAP_LIM)) ? COUNT_W'(CAP_LIM) : capacity;
  assign full    = count >= cap_eff;
  assign empty   = count == '0;
  assign new_data = VALUE_WIDTH'(req.value);

  always_comb begin
    is_ins      = 1'b0;
    is_rem      = 1'b0;
    op_pos      = '0;
    status_next = ST_OK;
    unique case (req.func)
      FN_INS_POS: begin
        is_ins = 1'b1;
        op_pos = req.position;
        if (full) status_next = ST_FULL;
        else if (req.position > count) status_next = ST_RANGE;
      end
      FN_INS_HEAD: begin
        is_ins = 1'b1;
        if (full) status_next = ST_FULL;
      end
      FN_INS_TAIL: begin
        is_ins = 1'b1;
        op_pos = count;
        if (full) status_next = ST_FULL;
      end
      FN_REM_POS: begin
        is_rem = 1'b1;
        op_pos = req.position;
        if (empty) status_next = ST_EMPTY;
        else if (req.position >= count) status_next = ST_RANGE;
      end
      FN_REM_HEAD: begin
        is_rem = 1'b1;
        if (empty) status_next = ST_EMPTY;
      end
      FN_REM_TAIL: begin
        is_rem = 1'b1;
        op_pos = count - 1'b1;
        if (empty) status_next = ST_EMPTY;
      end
      default: ;
    endcase
  end

  assign ctl.ins = accept && is_ins && (status_next == ST_OK);
  assign ctl.rem = accept && is_rem && (status_next == ST_OK);
  assign ctl.pos = op_pos;

  always_comb begin
    count_next = count;
    if (ctl.ins) count_next = count + 1'b1;
    else if (ctl.rem) count_next = count - 1'b1;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lo;
    logic [VALUE_WIDTH-1:0] hi;
    if (i == 0) begin : g_first
      assign lo = '0;
    end else begin : g_lo
      assign lo = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign hi = cell_data[i];
    end else begin : g_hi
      assign hi = cell_data[i+1];
    end
    ple_cell #(
      .IDX         (i),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .new_data (new_data),
      .lo_data  (lo),
      .hi_data  (hi),
      .data     (cell_data[i]),
      .sel_data (cell_sel[i])
    );
  end

  always_comb begin
    picked = '0;
    for (int i = 0; i < DEPTH; i++) begin
      picked = picked | cell_sel[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= COUNT_W'(64);
      count    <= '0;
      done     <= 1'b0;
    end else begin
      if (cfg_we) capacity <= cfg_data;
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status        <= status_next;
      rsp.removed_value <= ctl.rem ? DATA_W'(picked) : '0;
      rsp.count         <= count_next;
    end
  end

endmodule

FILE: rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell - one list slot
// Holds one entry. On an insert, slots above the insert slot take their lower
// neighbour's value (the new value at the insert slot); on a remove, slots at
// or above it take their upper neighbour's value. Offers its entry when it is the addressed slot.
// ----------------------------------------------------------------------------
module ple_cell #(
  parameter int unsigned IDX         = 0,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  ple_pkg::cell_ctl_t     ctl,
  input  logic [VALUE_WIDTH-1:0] new_data,
  input  logic [VALUE_WIDTH-1:0] lo_data,
  input  logic [VALUE_WIDTH-1:0] hi_data,
  output logic [VALUE_WIDTH-1:0] data,
  output logic [VALUE_WIDTH-1:0] sel_data
);
  import ple_pkg::*;

  localparam int unsigned POS_MAX = (1 << POS_W) - 1;

  logic at_pos;
  logic above_pos;

  assign at_pos    = (IDX <= POS_MAX) && (ctl.pos == POS_W'(IDX));
  assign above_pos = (IDX > POS_MAX) || (POS_W'(IDX) > ctl.pos);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (above_pos) begin
        data <= lo_data;
      end else if (at_pos) begin
        data <= new_data;
      end
    end else if (ctl.rem && (above_pos || at_pos)) begin
      data <= hi_data;
    end
  end

  assign sel_data = at_pos ? data : '0;

endmodule

FILE: rtl/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker - port-level checks for the positional list engine
// Watches request/response timing and response consistency.
// ----------------------------------------------------------------------------
module ple_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input ple_pkg::req_t req,
  input logic          done,
  input ple_pkg::rsp_t rsp
);
  import ple_pkg::*;

  a_resp_follows: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("transaction without response");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("response without transaction");

  a_fail_no_value: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.removed_value == '0)
    else $error("removed value on failed transaction");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    done && $past(done) && !$past(rst, 2) |->
      rsp.count == $past(rsp.count) || rsp.count == $past(rsp.count) + 1'b1 ||
      rsp.count == $past(rsp.count) - 1'b1)
    else $error("count moved by more than one");

endmodule

bind positional_list_engine ple_checker u_ple_checker (.*);
